/* rtl/tcfifo_pkg.sv */
// Shared codes, widths and interface types for the two-class FIFO block.
package tcfifo_pkg;

    localparam int PORT_ID_W       = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam logic [1:0] OP_ENQUEUE   = 2'd0;
    localparam logic [1:0] OP_DEQ_ANY   = 2'd1;
    localparam logic [1:0] OP_DEQ_CLS1  = 2'd2;
    localparam logic [1:0] OP_DEQ_CLS0  = 2'd3;

    localparam logic [1:0] ST_ENQUEUED  = 2'd0;
    localparam logic [1:0] ST_DEQUEUED  = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

/* rtl/tcfifo_queue.sv */
// One class FIFO: register-read store with a prefetched front entry.
module tcfifo_queue #(
    parameter int QUEUE_DEPTH = tcfifo_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = tcfifo_pkg::ID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcfifo_pkg::q_ctl_t  ctl,
    input  logic [ID_BITS-1:0]  push_id,
    output logic [ID_BITS-1:0]  front,
    output tcfifo_pkg::q_stat_t stat
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      head_next;
    logic [AW-1:0]      tail_reg;
    logic [AW-1:0]      tail_next;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [ID_BITS-1:0] front_reg;
    logic               push_ok;
    logic               pop_ok;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == FULL_CNT);
    assign push_ok    = ctl.push && !stat.full;
    assign pop_ok     = ctl.pop && !stat.empty;
    assign front      = front_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (pop_ok)
        begin
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        end
        if (push_ok)
        begin
            tail_next = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail_reg] <= push_id;
        end
    end

    // front follows the next head; a beat written there this cycle bypasses
    always_ff @(posedge clk)
    begin
        if (push_ok && (tail_reg == head_next))
        begin
            front_reg <= push_id;
        end
        else
        begin
            front_reg <= mem[head_next];
        end
    end

endmodule

/* rtl/two_class_fifo_oldest_first.sv */
// Two-class FIFO of sequence ids with oldest-first dequeue across classes.
// Each beat carries one request (enqueue, dequeue oldest, dequeue class 1,
// dequeue class 0) and yields exactly one result beat. The block takes one
// beat per cycle while no result waits on out_ready; an accepted beat sits in
// the input register, and its result is loaded into the result register once
// that register is free or being taken, and is presented from there.
// Each class FIFO holds QUEUE_DEPTH ids in
// a store with registered read; its front entry is prefetched into a
// register that the head compare and pop read. Enqueue to a full
// class drops the id with status full; a dequeue from empty returns status
// empty with zero data. Dequeue-oldest picks the smaller front id, class 1
// on a tie. in_ready drops only while a result waits on out_ready.
module two_class_fifo_oldest_first #(
    parameter int QUEUE_DEPTH = tcfifo_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = tcfifo_pkg::ID_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       op,
    input  logic [tcfifo_pkg::PORT_ID_W-1:0] item_id,
    input  logic                             item_class,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [tcfifo_pkg::PORT_ID_W-1:0] out_id,
    output logic                             out_class
);

    localparam int PW = tcfifo_pkg::PORT_ID_W;

    logic               in_valid_reg;
    logic [1:0]         op_reg;
    logic [ID_BITS-1:0] id_reg;
    logic               class_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic [PW-1:0]      out_id_reg;
    logic [PW-1:0]      out_id_next;
    logic               out_class_reg;
    logic               out_class_next;

    logic               fire;
    logic               sel_pop0;
    logic               sel_pop1;
    logic               sel_push0;
    logic               sel_push1;

    tcfifo_pkg::q_ctl_t  ctl0;
    tcfifo_pkg::q_ctl_t  ctl1;
    tcfifo_pkg::q_stat_t stat0;
    tcfifo_pkg::q_stat_t stat1;
    logic [ID_BITS-1:0]  front0;
    logic [ID_BITS-1:0]  front1;

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg    <= op;
            id_reg    <= ID_BITS'(item_id);
            class_reg <= item_class;
        end
    end

    always_comb
    begin
        sel_pop0       = 1'b0;
        sel_pop1       = 1'b0;
        sel_push0      = 1'b0;
        sel_push1      = 1'b0;
        status_next    = tcfifo_pkg::ST_EMPTY;
        out_id_next    = '0;
        out_class_next = 1'b0;
        case (op_reg)
            tcfifo_pkg::OP_ENQUEUE:
            begin
                if (class_reg ? stat1.full : stat0.full)
                begin
                    status_next = tcfifo_pkg::ST_FULL;
                end
                else
                begin
                    status_next = tcfifo_pkg::ST_ENQUEUED;
                    sel_push0   = !class_reg;
                    sel_push1   = class_reg;
                end
            end
            tcfifo_pkg::OP_DEQ_ANY:
            begin
                if (!stat0.empty && (stat1.empty || (front0 < front1)))
                begin
                    sel_pop0 = 1'b1;
                end
                else if (!stat1.empty)
                begin
                    sel_pop1 = 1'b1;
                end
            end
            tcfifo_pkg::OP_DEQ_CLS1:
            begin
                sel_pop1 = !stat1.empty;
            end
            tcfifo_pkg::OP_DEQ_CLS0:
            begin
                sel_pop0 = !stat0.empty;
            end
            default:
            begin
                status_next = tcfifo_pkg::ST_EMPTY;
            end
        endcase
        if (sel_pop0)
        begin
            status_next = tcfifo_pkg::ST_DEQUEUED;
            out_id_next = PW'(front0);
        end
        else if (sel_pop1)
        begin
            status_next    = tcfifo_pkg::ST_DEQUEUED;
            out_id_next    = PW'(front1);
            out_class_next = 1'b1;
        end
    end

    assign ctl0.push = fire && sel_push0;
    assign ctl0.pop  = fire && sel_pop0;
    assign ctl1.push = fire && sel_push1;
    assign ctl1.pop  = fire && sel_pop1;

    tcfifo_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_q0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl0),
        .push_id (id_reg),
        .front   (front0),
        .stat    (stat0)
    );

    tcfifo_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_q1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl1),
        .push_id (id_reg),
        .front   (front1),
        .stat    (stat1)
    );

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg    <= status_next;
            out_id_reg    <= out_id_next;
            out_class_reg <= out_class_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_id    = out_id_reg;
    assign out_class = out_class_reg;

    a_q_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat0.empty && stat0.full) && !(stat1.empty && stat1.full))
        else $error("class FIFO reports empty and full at once");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a held result");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != tcfifo_pkg::ST_DEQUEUED)) |->
            ((out_id == '0) && !out_class))
        else $error("non-dequeue result carries data");

    a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl0.pop && ctl1.pop) && !((ctl0.pop || ctl1.pop) && (ctl0.push || ctl1.push)))
        else $error("more than one queue action in a cycle");

endmodule

/* tb/sv/tb_two_class_fifo_oldest_first.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the two-class oldest-first FIFO block.
module tb_two_class_fifo_oldest_first;

    localparam int PORT_ID_W      = tcfifo_pkg::PORT_ID_W;
    localparam int DEPTH          = tcfifo_pkg::QUEUE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 10;
    localparam logic [PORT_ID_W-1:0] ID_MASK =
        PORT_ID_W'((64'd1 << tcfifo_pkg::ID_BITS_DEF) - 1);

    typedef struct {
        logic [1:0]           status;
        logic [PORT_ID_W-1:0] id;
        logic                 cls;
    } fifo_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           op;
    logic [PORT_ID_W-1:0] item_id;
    logic                 item_class;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           status;
    logic [PORT_ID_W-1:0] out_id;
    logic                 out_class;

    logic [PORT_ID_W-1:0] class_ids [2][DEPTH];
    int                   class_head [2];
    int                   class_fill [2];
    fifo_result_t         pending_results [$];

    int                   in_idle_pct;
    int                   out_idle_pct;
    int                   fail_count;
    int                   stall_cycles;
    logic [PORT_ID_W-1:0] next_seq;

    two_class_fifo_oldest_first u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .item_id    (item_id),
        .item_class (item_class),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_id     (out_id),
        .out_class  (out_class)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic fifo_result_t serve_request(input logic [1:0] req_op,
                                                   input logic [PORT_ID_W-1:0] req_id,
                                                   input logic req_cls);
        fifo_result_t r;
        int           src;
        int           slot;
        r.status = tcfifo_pkg::ST_EMPTY;
        r.id     = '0;
        r.cls    = 1'b0;
        src      = -1;
        case (req_op)
            tcfifo_pkg::OP_ENQUEUE:
            begin
                if (class_fill[req_cls] >= DEPTH)
                    r.status = tcfifo_pkg::ST_FULL;
                else
                begin
                    slot = (class_head[req_cls] + class_fill[req_cls]) % DEPTH;
                    class_ids[req_cls][slot] = req_id & ID_MASK;
                    class_fill[req_cls]++;
                    r.status = tcfifo_pkg::ST_ENQUEUED;
                end
            end
            tcfifo_pkg::OP_DEQ_ANY:
            begin
                if (class_fill[0] == 0 && class_fill[1] == 0)
                    src = -1;
                else if (class_fill[1] == 0)
                    src = 0;
                else if (class_fill[0] == 0)
                    src = 1;
                else if (class_ids[0][class_head[0]] < class_ids[1][class_head[1]])
                    src = 0;
                else
                    src = 1;
            end
            tcfifo_pkg::OP_DEQ_CLS1:
            begin
                if (class_fill[1] != 0)
                    src = 1;
            end
            tcfifo_pkg::OP_DEQ_CLS0:
            begin
                if (class_fill[0] != 0)
                    src = 0;
            end
            default:
            begin
                src = -1;
            end
        endcase
        if (req_op != tcfifo_pkg::OP_ENQUEUE && src >= 0)
        begin
            r.status        = tcfifo_pkg::ST_DEQUEUED;
            r.id            = class_ids[src][class_head[src]];
            r.cls           = src[0];
            class_head[src] = (class_head[src] + 1) % DEPTH;
            class_fill[src]--;
        end
        return r;
    endfunction

    // predict on input beats, check output beats, watch for a hang
    always @(posedge clk)
    begin
        fifo_result_t exp_r;
        logic         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && in_ready)
            begin
                pending_results.push_back(serve_request(op, item_id, item_class));
                moved = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result beat: status %0d, out_id %0h, out_class %0d",
                           status, out_id, out_class);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (status !== exp_r.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_r.status, status);
                        fail_count++;
                    end
                    if (out_id !== exp_r.id)
                    begin
                        $error("out_id mismatch: expected %0h, actual %0h", exp_r.id, out_id);
                        fail_count++;
                    end
                    if (out_class !== exp_r.cls)
                    begin
                        $error("out_class mismatch: expected %0d, actual %0d",
                               exp_r.cls, out_class);
                        fail_count++;
                    end
                end
            end
            if (moved)
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    always @(negedge clk)
        out_ready = rst_n && ($urandom_range(99) >= out_idle_pct);

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [1:0] req_op, input logic [PORT_ID_W-1:0] req_id,
                             input logic req_cls);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        op         = req_op;
        item_id    = req_id;
        item_class = req_cls;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_empty_and_ties();
        send_beat(tcfifo_pkg::OP_DEQ_ANY,  16'h1111, 1'b1);
        send_beat(tcfifo_pkg::OP_DEQ_CLS1, 16'h2222, 1'b0);
        send_beat(tcfifo_pkg::OP_DEQ_CLS0, 16'hFFFF, 1'b1);
        send_beat(tcfifo_pkg::OP_ENQUEUE,  16'hFFFF, 1'b0);
        send_beat(tcfifo_pkg::OP_ENQUEUE,  16'h0000, 1'b1);
        send_beat(tcfifo_pkg::OP_DEQ_ANY,  16'h0000, 1'b0);   // smaller head wins
        send_beat(tcfifo_pkg::OP_ENQUEUE,  16'hFFFF, 1'b1);
        send_beat(tcfifo_pkg::OP_DEQ_ANY,  16'h0000, 1'b0);   // tie goes to class 1
        send_beat(tcfifo_pkg::OP_DEQ_ANY,  16'h0000, 1'b0);   // only class 0 holds
        send_beat(tcfifo_pkg::OP_ENQUEUE,  16'h8000, 1'b1);
        send_beat(tcfifo_pkg::OP_DEQ_ANY,  16'h0000, 1'b0);   // only class 1 holds
    endtask

    task automatic test_full_drop();
        for (int i = 0; i < DEPTH; i++)
            send_beat(tcfifo_pkg::OP_ENQUEUE, PORT_ID_W'($urandom_range(65535)), 1'b0);
        send_beat(tcfifo_pkg::OP_ENQUEUE, 16'h5A5A, 1'b0);    // dropped
        send_beat(tcfifo_pkg::OP_DEQ_CLS0, 16'h0000, 1'b0);
        send_beat(tcfifo_pkg::OP_DEQ_CLS1, 16'h0000, 1'b1);   // class 1 still empty
    endtask

    task automatic test_random_traffic(input int in_pct, input int out_pct, input int count);
        int                   mode;
        int                   burst_left;
        int                   enq_pct;
        int                   pick;
        logic [1:0]           req_op;
        logic [PORT_ID_W-1:0] req_id;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        burst_left   = 0;
        enq_pct      = 50;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                mode       = $urandom_range(2);
                burst_left = $urandom_range(8, 40);
                enq_pct    = (mode == 0) ? 75 : (mode == 1) ? 20 : 50;
            end
            burst_left--;
            if ($urandom_range(99) < enq_pct)
                req_op = tcfifo_pkg::OP_ENQUEUE;
            else
            begin
                pick = $urandom_range(3);
                if (pick < 2)
                    req_op = tcfifo_pkg::OP_DEQ_ANY;
                else if (pick == 2)
                    req_op = tcfifo_pkg::OP_DEQ_CLS1;
                else
                    req_op = tcfifo_pkg::OP_DEQ_CLS0;
            end
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                req_id   = next_seq;
                next_seq = next_seq + PORT_ID_W'($urandom_range(1, 3));
            end
            else if (pick < 85)
                req_id = PORT_ID_W'($urandom_range(65535));
            else if (pick < 95)
                req_id = PORT_ID_W'($urandom_range(3));
            else
                req_id = $urandom_range(1) ? '1 : '0;
            send_beat(req_op, req_id, 1'($urandom_range(1)));
            if (n == count / 2)
                hold_until_drained();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = tcfifo_pkg::OP_ENQUEUE;
        item_id      = '0;
        item_class   = 1'b0;
        out_ready    = 1'b0;
        in_idle_pct  = 26;
        out_idle_pct = 51;
        fail_count   = 0;
        stall_cycles = 0;
        next_seq     = PORT_ID_W'($urandom_range(65535));
        for (int c = 0; c < 2; c++)
        begin
            class_head[c] = 0;
            class_fill[c] = 0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_ties();
        test_full_drop();
        test_random_traffic(26, 51, 620);
        hold_until_drained();
        test_random_traffic(51, 26, 620);
        hold_until_drained();
        test_random_traffic(0, 0, 620);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/tcfifo_pkg.sv
rtl/tcfifo_queue.sv
rtl/two_class_fifo_oldest_first.sv
tb/sv/tb_two_class_fifo_oldest_first.sv
